FILE: src/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the limit order book matcher
// Request layouts, the resting order entry, chain control and FSM states.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int PRICE_W    = 10;
    localparam int QTY_W      = 32;
    localparam int ID_W       = 32;
    localparam int POOL_DEPTH = 64;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] order_price;
        logic [QTY_W-1:0]   order_quantity;
        logic [ID_W-1:0]    ord_ident;
        logic [ID_W-1:0]    acct_ident;
    } t_in_req;

    typedef struct packed {
        logic [ID_W-1:0]    maker_order_id;
        logic [ID_W-1:0]    taker_order_id;
        logic [PRICE_W-1:0] fill_price;
        logic [QTY_W-1:0]   fill_quantity;
        logic               last_fill;
    } t_out_req;

    // One resting order as held in a cell.
    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    ord_ident;
        logic [QTY_W-1:0]   qty;
    } t_entry;

    typedef struct packed {
        logic             ascending;
        logic             ins;
        logic             pop;
        logic             dec;
        logic [QTY_W-1:0] dec_qty;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_REST
    } t_state;

endpackage

FILE: src/limit_order_book_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit: price-time priority limit order matcher
// Matches incoming limit orders against a book of up to POOL_DEPTH orders.
// ----------------------------------------------------------------------------
// Each input request is one limit order (side, price, quantity, ids). The
// block accepts a request only while idle; o_in_stall is high otherwise.
// A buy trades against resting asks priced at or below its limit, a sell
// against resting bids priced at or above its limit; bids resting at price
// zero are never hit. Makers are taken best price first, oldest first within
// a price. Every maker touched produces one output request, and last_fill
// marks the final one of the order.
// Steps: IDLE accepts the request; MATCH makes a fill per crossing maker
// while the output side takes requests, until a MATCH step finds no further
// crossing maker; REST then rests any remainder before the return to IDLE.
// From MATCH, the first fill enters the output register once that is free.
// Each chain's single front cell sets the fill rate: one per unstalled cycle.
// When the receiver stalls, the fill sits in the output register and the
// matcher waits. A remainder is dropped when the book already holds
// POOL_DEPTH orders. Reset empties the book at once (cell valid bits).
// The account of a resting order is not kept, since nothing ever reads it.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lobm_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lobm_pkg::t_out_req o_out_req
);
    import lobm_pkg::*;

    t_state r_state;
    t_state n_state;

    // The order being worked on.
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_rem;
    logic [ID_W-1:0]    r_oid;

    logic [CNT_W-1:0]   r_count;

    logic               r_out_valid;
    t_out_req           r_out;

    t_entry     w_bid0, w_bid1, w_ask0, w_ask1;
    t_entry     w_opp0, w_opp1, w_new;
    t_chain_ctl w_bid_ctl, w_ask_ctl;

    logic             w_accept;
    logic             w_can_emit;
    logic             w_cross0, w_cross1;
    logic             w_fire;
    logic             w_full;
    logic             w_ins;
    logic [QTY_W-1:0] w_fill_qty;
    logic [QTY_W-1:0] w_rem_next;

    // Whether a resting maker may trade with the current order.
    function automatic logic crosses(input t_entry e, input logic side,
                                     input logic [PRICE_W-1:0] price);
        logic res;
        if (side == SIDE_BUY) begin
            res = e.valid && (e.price <= price);
        end else begin
            res = e.valid && (e.price >= price) && (e.price != '0);
        end
        return res;
    endfunction

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_can_emit = !r_out_valid || !i_out_stall;

    // The opposite side's chain supplies the makers.
    assign w_opp0 = (r_side == SIDE_BUY) ? w_ask0 : w_bid0;
    assign w_opp1 = (r_side == SIDE_BUY) ? w_ask1 : w_bid1;

    assign w_cross0   = (r_rem != '0) && crosses(w_opp0, r_side, r_price);
    assign w_cross1   = crosses(w_opp1, r_side, r_price);
    assign w_full     = (w_opp0.qty <= r_rem);
    assign w_fill_qty = w_full ? w_opp0.qty : r_rem;
    assign w_rem_next = r_rem - w_fill_qty;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (!w_cross0) begin
                    n_state = ST_REST;
                end
            end
            ST_REST: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_fire     = 1'b0;
        w_ins      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_MATCH: begin
                w_fire = w_cross0 && w_can_emit;
            end
            ST_REST: begin
                w_ins = (r_rem != '0) && (r_count < CNT_W'(POOL_DEPTH));
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_new.valid     = 1'b1;
    assign w_new.price     = r_price;
    assign w_new.ord_ident = r_oid;
    assign w_new.qty       = r_rem;

    // A fill pops or trims the opposite front; a remainder joins its own side.
    always_comb begin
        w_bid_ctl.ascending = 1'b0;
        w_bid_ctl.ins       = w_ins && (r_side == SIDE_BUY);
        w_bid_ctl.pop       = w_fire && (r_side == SIDE_SELL) && w_full;
        w_bid_ctl.dec       = w_fire && (r_side == SIDE_SELL) && !w_full;
        w_bid_ctl.dec_qty   = w_fill_qty;
        w_ask_ctl.ascending = 1'b1;
        w_ask_ctl.ins       = w_ins && (r_side == SIDE_SELL);
        w_ask_ctl.pop       = w_fire && (r_side == SIDE_BUY) && w_full;
        w_ask_ctl.dec       = w_fire && (r_side == SIDE_BUY) && !w_full;
        w_ask_ctl.dec_qty   = w_fill_qty;
    end

    lobm_chain u_bid_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_bid_ctl),
        .i_new    (w_new),
        .o_front0 (w_bid0),
        .o_front1 (w_bid1)
    );

    lobm_chain u_ask_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ask_ctl),
        .i_new    (w_new),
        .o_front0 (w_ask0),
        .o_front1 (w_ask1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_fire && w_full) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_can_emit) begin
                r_out_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_side  <= i_in_req.side;
            r_price <= i_in_req.order_price;
            r_rem   <= i_in_req.order_quantity;
            r_oid   <= i_in_req.ord_ident;
        end else if (w_fire) begin
            r_rem <= w_rem_next;
        end
        if (w_fire) begin
            r_out.maker_order_id <= w_opp0.ord_ident;
            r_out.taker_order_id <= r_oid;
            r_out.fill_price     <= w_opp0.price;
            r_out.fill_quantity  <= w_fill_qty;
            // No further fill if the order is spent or the next maker does not cross.
            r_out.last_fill      <= (w_rem_next == '0) || !w_full || !w_cross1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POOL_DEPTH))
        else $error("book holds more orders than the pool allows");

    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("fill did not reach the output register");

    a_accept_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MATCH))
        else $error("accepted order did not start matching");

    a_no_ins_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ins && w_fire))
        else $error("insert and fill in the same cycle");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (w_fill_qty != '0))
        else $error("zero quantity fill");

endmodule

FILE: src/lobm_cell.sv
// ----------------------------------------------------------------------------
// lobm_cell: one slot of a sorted order chain
// Holds one resting order; shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module lobm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lobm_pkg::t_chain_ctl i_ctl,
    input  lobm_pkg::t_entry    i_new,
    input  lobm_pkg::t_entry    i_left,
    input  logic                i_left_after,
    input  lobm_pkg::t_entry    i_right,
    input  logic                i_front,
    output lobm_pkg::t_entry    o_entry,
    output logic                o_after
);
    import lobm_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // The new order belongs behind this one: better price, or same price and older.
    assign o_after = r_ent.valid &&
                     (i_ctl.ascending ? (r_ent.price <= i_new.price)
                                      : (r_ent.price >= i_new.price));

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.pop) begin
            n_ent = i_right;
        end else if (i_ctl.dec && i_front) begin
            n_ent.qty = r_ent.qty - i_ctl.dec_qty;
        end else if (i_ctl.ins && !o_after) begin
            n_ent = i_left_after ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_entry = r_ent;

endmodule

FILE: src/lobm_chain.sv
// ----------------------------------------------------------------------------
// lobm_chain: row of cells holding one side of the book in priority order
// Cell zero always holds the best resting order of this side.
// ----------------------------------------------------------------------------
module lobm_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lobm_pkg::t_chain_ctl i_ctl,
    input  lobm_pkg::t_entry     i_new,
    output lobm_pkg::t_entry     o_front0,
    output lobm_pkg::t_entry     o_front1
);
    import lobm_pkg::*;

    t_entry w_ent   [POOL_DEPTH];
    logic   w_after [POOL_DEPTH];

    for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_after;

        if (i == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_after = 1'b1;
        end else begin : g_mid
            assign w_left       = w_ent[i-1];
            assign w_left_after = w_after[i-1];
        end

        if (i == POOL_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_ent[i+1];
        end

        lobm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_new        (i_new),
            .i_left       (w_left),
            .i_left_after (w_left_after),
            .i_right      (w_right),
            .i_front      (i == 0),
            .o_entry      (w_ent[i]),
            .o_after      (w_after[i])
        );
    end

    assign o_front0 = w_ent[0];
    assign o_front1 = w_ent[1];

endmodule

FILE: sim/limit_order_book_matcher_checker.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_checker: fill predictor and scoreboard
// Keeps its own copy of the book, predicts the fills of every accepted order
// and compares each fill that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  lobm_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lobm_pkg::t_out_req i_out_req,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_fills
);
    timeunit 1ns;
    timeprecision 1ps;
    import lobm_pkg::*;

    localparam int TOP_LEVEL  = 1023;
    localparam int NIL        = POOL_DEPTH;
    localparam int FILL_LIMIT = 64;

    int unsigned bid_head [TOP_LEVEL+1];
    int unsigned bid_tail [TOP_LEVEL+1];
    int unsigned ask_head [TOP_LEVEL+1];
    int unsigned ask_tail [TOP_LEVEL+1];
    logic [ID_W-1:0]  pool_id   [POOL_DEPTH];
    logic [QTY_W-1:0] pool_qty  [POOL_DEPTH];
    int unsigned      pool_next [POOL_DEPTH];
    int unsigned      pool_prev [POOL_DEPTH];
    bit               pool_free [POOL_DEPTH];
    int unsigned      best_bid;
    int unsigned      best_ask;

    t_out_req expected_fills[$];

    int errors      = 0;
    int fills       = 0;
    int pending_cnt = 0;
    assign o_errors  = errors;
    assign o_pending = pending_cnt;
    assign o_fills   = fills;

    function automatic void clear_book();
        for (int i = 0; i <= TOP_LEVEL; i++) begin
            bid_head[i] = NIL;
            bid_tail[i] = NIL;
            ask_head[i] = NIL;
            ask_tail[i] = NIL;
        end
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_next[i] = NIL;
            pool_prev[i] = NIL;
            pool_free[i] = 1'b1;
        end
        best_bid = 0;
        best_ask = TOP_LEVEL;
    endfunction

    function automatic void level_append(logic is_ask, int unsigned lvl, int unsigned e);
        int unsigned t;
        t = is_ask ? ask_tail[lvl] : bid_tail[lvl];
        pool_prev[e] = t;
        pool_next[e] = NIL;
        if (t < NIL) begin
            pool_next[t] = e;
        end else if (is_ask) begin
            ask_head[lvl] = e;
        end else begin
            bid_head[lvl] = e;
        end
        if (is_ask) ask_tail[lvl] = e;
        else bid_tail[lvl] = e;
    endfunction

    function automatic void level_unlink(logic is_ask, int unsigned lvl, int unsigned e);
        int unsigned p;
        int unsigned n;
        p = pool_prev[e];
        n = pool_next[e];
        if (p < NIL) pool_next[p] = n;
        else if (is_ask) ask_head[lvl] = n;
        else bid_head[lvl] = n;
        if (n < NIL) pool_prev[n] = p;
        else if (is_ask) ask_tail[lvl] = p;
        else bid_tail[lvl] = p;
        pool_free[e] = 1'b1;
    endfunction

    // Walks the opposite side best price first, oldest maker first, then rests
    // whatever is left of the order in the lowest free pool entry.
    function automatic void match_order(t_in_req r);
        logic [QTY_W-1:0] rem;
        logic [QTY_W-1:0] m;
        int unsigned      lvl;
        int unsigned      cur;
        int unsigned      nxt;
        int unsigned      e;
        logic             hits_asks;
        t_out_req         batch[$];
        t_out_req         f;
        rem = r.order_quantity;
        hits_asks = (r.side == SIDE_BUY);
        while (rem != 0 && batch.size() < FILL_LIMIT) begin
            if (hits_asks) begin
                if (best_ask > r.order_price) break;
                lvl = best_ask;
            end else begin
                if (best_bid < r.order_price || best_bid == 0) break;
                lvl = best_bid;
            end
            cur = hits_asks ? ask_head[lvl] : bid_head[lvl];
            while (rem != 0 && cur < NIL && batch.size() < FILL_LIMIT) begin
                nxt = pool_next[cur];
                m = (rem < pool_qty[cur]) ? rem : pool_qty[cur];
                f.maker_order_id = pool_id[cur];
                f.taker_order_id = r.ord_ident;
                f.fill_price     = lvl[PRICE_W-1:0];
                f.fill_quantity  = m;
                f.last_fill      = 1'b0;
                batch = {batch, f};
                rem = rem - m;
                pool_qty[cur] = pool_qty[cur] - m;
                if (pool_qty[cur] == 0) level_unlink(hits_asks, lvl, cur);
                cur = nxt;
            end
            if (hits_asks && ask_head[lvl] >= NIL) begin
                while (best_ask <= TOP_LEVEL && ask_head[best_ask] >= NIL) best_ask++;
            end else if (!hits_asks && bid_head[lvl] >= NIL) begin
                while (best_bid > 0 && bid_head[best_bid] >= NIL) best_bid--;
            end
        end
        if (rem != 0) begin
            e = NIL;
            for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
                if (pool_free[i]) e = i;
            end
            if (e < NIL) begin
                pool_free[e] = 1'b0;
                pool_id[e]   = r.ord_ident;
                pool_qty[e]  = rem;
                // The resting side is the order's own side.
                level_append(!hits_asks, r.order_price, e);
                if (hits_asks && r.order_price > best_bid) best_bid = r.order_price;
                if (!hits_asks && r.order_price < best_ask) best_ask = r.order_price;
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last_fill = 1'b1;
        foreach (batch[i]) expected_fills = {expected_fills, batch[i]};
    endfunction

    always @(posedge i_clk) begin
        t_out_req exp_fill;
        if (!i_rst_n) begin
            clear_book();
            expected_fills.delete();
            pending_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                fills++;
                if (expected_fills.size() == 0) begin
                    $error("unexpected fill: maker %0d taker %0d",
                           i_out_req.maker_order_id, i_out_req.taker_order_id);
                    errors++;
                end else begin
                    exp_fill = expected_fills.pop_front();
                    if (exp_fill.maker_order_id !== i_out_req.maker_order_id) begin
                        $error("maker_order_id: expected %0d, got %0d",
                               exp_fill.maker_order_id, i_out_req.maker_order_id);
                        errors++;
                    end
                    if (exp_fill.taker_order_id !== i_out_req.taker_order_id) begin
                        $error("taker_order_id: expected %0d, got %0d",
                               exp_fill.taker_order_id, i_out_req.taker_order_id);
                        errors++;
                    end
                    if (exp_fill.fill_price !== i_out_req.fill_price) begin
                        $error("fill_price: expected %0d, got %0d",
                               exp_fill.fill_price, i_out_req.fill_price);
                        errors++;
                    end
                    if (exp_fill.fill_quantity !== i_out_req.fill_quantity) begin
                        $error("fill_quantity: expected %0d, got %0d",
                               exp_fill.fill_quantity, i_out_req.fill_quantity);
                        errors++;
                    end
                    if (exp_fill.last_fill !== i_out_req.last_fill) begin
                        $error("last_fill: expected %0d, got %0d",
                               exp_fill.last_fill, i_out_req.last_fill);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) match_order(i_in_req);
            pending_cnt = expected_fills.size();
        end
    end

endmodule

FILE: sim/limit_order_book_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit_tb: testbench of the order matcher
// Sends directed and random limit orders, lets the checker predict and compare
// the fills, stalls the fill side at random and once for a long stretch.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lobm_pkg::*;

    logic     i_clk      = 1'b0;
    logic     i_rst_n    = 1'b0;
    logic     in_valid   = 1'b0;
    logic     out_stall  = 1'b0;
    t_in_req  in_req     = '0;
    logic     in_stall;
    logic     out_valid;
    t_out_req out_req;
    int       errors;
    int       pending;
    int       fills;

    // Shared controls between the order sender and the fill-side staller.
    bit no_gaps   = 1'b0;
    bit hold_req  = 1'b0;
    int orders    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    limit_order_book_matcher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    limit_order_book_matcher_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_req   (out_req),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_fills     (fills)
    );

    // Offers one order request and returns at the edge that accepts it. Random
    // idle cycles go in front unless the no-gap stretch is on. Valid stays high
    // straight into the next request when no idle cycle falls in between.
    task automatic send_order(logic side, int unsigned price, logic [QTY_W-1:0] qty);
        t_in_req r;
        r.side           = side;
        r.order_price    = price[PRICE_W-1:0];
        r.order_quantity = qty;
        r.ord_ident      = $urandom;
        r.acct_ident     = $urandom;
        while (!no_gaps && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge i_clk); while (in_stall);
        orders++;
    endtask

    // Mostly a narrow price band around the middle so that orders cross often,
    // with the occasional full-range price, huge quantity or empty order.
    task automatic send_banded_order();
        int unsigned      price;
        logic [QTY_W-1:0] qty;
        price = 480 + $urandom_range(15);
        qty   = $urandom_range(200, 1);
        if ($urandom_range(19) == 0) price = $urandom_range(1023);
        if ($urandom_range(9) == 0) qty = $urandom;
        if ($urandom_range(19) == 0) qty = '0;
        send_order($urandom_range(1), price, qty);
    endtask

    // Fill-side staller: random stalls, none during the no-gap stretch, and one
    // long hold-off while the sender keeps offering so the block backs up.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                repeat (300) begin
                    out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 31);
        end
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty order does nothing at all.
        send_order(SIDE_BUY, 500, '0);
        // An ask at the lowest price, taken in two pieces down to empty.
        send_order(SIDE_SELL, 0, 5);
        send_order(SIDE_BUY, 0, 2);
        send_order(SIDE_BUY, 1023, 3);
        // A bid at price zero rests but a sell at zero must not hit it.
        send_order(SIDE_BUY, 0, 10);
        send_order(SIDE_SELL, 0, 4);
        send_order(SIDE_BUY, 0, 4);
        // Three makers at one level swept by a maximal buy that then rests.
        send_order(SIDE_SELL, 700, 10);
        send_order(SIDE_SELL, 700, 20);
        send_order(SIDE_SELL, 700, 30);
        send_order(SIDE_BUY, 1023, 32'hFFFF_FFFF);
        // Maximal sell at the top level, then a sweep down to the zero bid.
        send_order(SIDE_SELL, 1023, 32'hFFFF_FFFF);
        send_order(SIDE_BUY, 600, 7);
        send_order(SIDE_SELL, 0, 32'hFFFF_FFFF);
        send_order(SIDE_BUY, 1023, 32'hFFFF_FFFF);
        send_order(SIDE_SELL, 1, 32'hFFFF_FFFF);
        send_order(SIDE_SELL, 512, 32'h8000_0000);

        // Random crossing traffic, with the long hold-off and a gap-free stretch.
        for (int i = 0; i < 120; i++) begin
            if (i == 40) hold_req = 1'b1;
            no_gaps = (i >= 60 && i < 100);
            send_banded_order();
        end
        no_gaps = 1'b0;

        // Fill the pool with small bids low in the book so later remainders
        // are dropped, then sweep them with big sells for long fill bursts.
        for (int i = 0; i < 70; i++) begin
            send_order(SIDE_BUY, $urandom_range(8, 1), $urandom_range(50, 1));
        end
        for (int i = 0; i < 4; i++) begin
            send_order(SIDE_SELL, 1, 32'hFFFF_FFFF - $urandom_range(3));
        end
        for (int i = 0; i < 60; i++) send_banded_order();

        in_valid <= 1'b0;
        // Let the checker take in the last order before watching its backlog.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d order requests and %0d fills, including a full pool,",
                 orders, fills);
        $display("long fill bursts, empty orders and a 300-cycle fill-side hold-off.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
